// ----- rtl/core/wsfd_pkg.sv -----
package wsfd_pkg;

	localparam int unsigned LEN_W = 64;
	localparam int unsigned KEY_W = 32;
	localparam int unsigned CNT_W = 4;

	// Parser phases.
	localparam logic [2:0] PH_HDR0 = 3'd0;
	localparam logic [2:0] PH_HDR1 = 3'd1;
	localparam logic [2:0] PH_EXT  = 3'd2;
	localparam logic [2:0] PH_MASK = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;

	// Seven-bit length codes that announce an extended length.
	localparam logic [6:0] LEN_CODE16 = 7'd126;
	localparam logic [6:0] LEN_CODE64 = 7'd127;

	// Header bytes still due after the second header byte.
	localparam logic [CNT_W-1:0] EXT16_BYTES = 4'd2;
	localparam logic [CNT_W-1:0] EXT64_BYTES = 4'd8;
	localparam logic [CNT_W-1:0] KEY_BYTES   = 4'd4;

	typedef struct packed {
		logic       valid;
		logic [7:0] payload_byte;
		logic       has_byte;
		logic       frame_end;
	} result_t;

endpackage

// ----- rtl/core/wsfd_byte_if.sv -----
interface wsfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// ----- rtl/core/wsfd_result_if.sv -----
interface wsfd_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       has_byte;
	logic       frame_end;

	modport source (output valid, output payload_byte, output has_byte, output frame_end,
		input ready);
	modport sink (input valid, input payload_byte, input has_byte, input frame_end,
		output ready);
endinterface

// ----- rtl/core/websocket_frame_decoder_top.sv -----
// WebSocket frame decoder.
//
// The stream channel takes the received byte stream, one word per byte, and
// the payload channel gives one word per payload byte with the mask removed.
// Frames follow one another with no gap: two header bytes, an optional 16-bit
// or 64-bit big-endian extended length, an optional four-byte mask key, then
// the payload. Header bytes give no word, except that a frame of zero length
// gives a single word with has_byte low and frame_end high on the byte that
// completes its header. The last payload byte of a frame carries frame_end.
//
// An accepted byte is registered in the input register and parsed from there;
// its word, if any, is registered in the output register and offered from
// it. While the output is not stalled, one byte can be accepted in every
// cycle; the rate is set by the parser's state update, which is a single
// step per byte.
// Reset clears the parser to expect a first header byte and empties both
// registers. When the receiver stalls the output register holds its word; the
// input register takes at most one more byte, only if it is empty, and then
// stream.ready stays low until the output word is taken.
module websocket_frame_decoder_top (
	input  logic          clk,
	input  logic          arst_n,
	wsfd_byte_if.sink     stream,
	wsfd_result_if.source payload
);
	import wsfd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       res_valid_s2;
	result_t    res_s2;
	result_t    res;
	logic       advance;
	logic       step;

	// The parser moves on whenever its result has somewhere to go.
	assign advance      = !res_valid_s2 || payload.ready;
	assign step         = valid_s1 && advance;
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.data_byte;
		end
	end

	wsfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= step && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			res_s2 <= res;
		end
	end

	assign payload.valid        = res_valid_s2;
	assign payload.payload_byte = res_s2.payload_byte;
	assign payload.has_byte     = res_s2.has_byte;
	assign payload.frame_end    = res_s2.frame_end;

endmodule

// ----- rtl/core/wsfd_parser.sv -----
module wsfd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data_byte,
	output wsfd_pkg::result_t res
);
	import wsfd_pkg::*;

	logic [2:0]       phase_q, phase_d;
	logic [CNT_W-1:0] hdr_cnt_q, hdr_cnt_d;
	logic [LEN_W-1:0] remaining_q, remaining_d;
	logic [KEY_W-1:0] key_q, key_d;
	logic             masked_q, masked_d;
	logic [1:0]       mask_pos_q, mask_pos_d;
	logic [6:0]       len7;
	logic [7:0]       key_byte;

	always_comb begin
		case (mask_pos_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	assign len7 = data_byte[6:0];

	always_comb begin
		phase_d     = phase_q;
		hdr_cnt_d   = hdr_cnt_q;
		remaining_d = remaining_q;
		key_d       = key_q;
		masked_d    = masked_q;
		mask_pos_d  = mask_pos_q;
		res         = '0;
		case (phase_q)
			PH_HDR1: begin
				masked_d    = data_byte[7];
				mask_pos_d  = 2'd0;
				key_d       = '0;
				remaining_d = '0;
				if (len7 == LEN_CODE16) begin
					hdr_cnt_d = EXT16_BYTES;
					phase_d   = PH_EXT;
				end else if (len7 == LEN_CODE64) begin
					hdr_cnt_d = EXT64_BYTES;
					phase_d   = PH_EXT;
				end else begin
					remaining_d = {{(LEN_W-7){1'b0}}, len7};
					if (data_byte[7]) begin
						hdr_cnt_d = KEY_BYTES;
						phase_d   = PH_MASK;
					end else if (len7 == 7'd0) begin
						phase_d       = PH_HDR0;
						res.valid     = 1'b1;
						res.frame_end = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_EXT: begin
				remaining_d = {remaining_q[LEN_W-9:0], data_byte};
				hdr_cnt_d   = hdr_cnt_q - 1'b1;
				if (hdr_cnt_q == 4'd1) begin
					if (masked_q) begin
						hdr_cnt_d = KEY_BYTES;
						phase_d   = PH_MASK;
					end else if (remaining_d == '0) begin
						phase_d       = PH_HDR0;
						res.valid     = 1'b1;
						res.frame_end = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_MASK: begin
				key_d     = {key_q[KEY_W-9:0], data_byte};
				hdr_cnt_d = hdr_cnt_q - 1'b1;
				if (hdr_cnt_q == 4'd1) begin
					if (remaining_q == '0) begin
						phase_d       = PH_HDR0;
						res.valid     = 1'b1;
						res.frame_end = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				mask_pos_d       = mask_pos_q + 2'd1;
				remaining_d      = remaining_q - 1'b1;
				res.valid        = 1'b1;
				res.has_byte     = 1'b1;
				res.payload_byte = masked_q ? (data_byte ^ key_byte) : data_byte;
				if (remaining_q == {{(LEN_W-1){1'b0}}, 1'b1}) begin
					phase_d       = PH_HDR0;
					res.frame_end = 1'b1;
				end
			end
			default: begin
				// First header byte: opcode, FIN and reserved bits are not used.
				phase_d = PH_HDR1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR0;
			hdr_cnt_q   <= '0;
			remaining_q <= '0;
			key_q       <= '0;
			masked_q    <= 1'b0;
			mask_pos_q  <= 2'd0;
		end else if (step) begin
			phase_q     <= phase_d;
			hdr_cnt_q   <= hdr_cnt_d;
			remaining_q <= remaining_d;
			key_q       <= key_d;
			masked_q    <= masked_d;
			mask_pos_q  <= mask_pos_d;
		end
	end

	// The data phase is only entered with bytes still owed.
	a_data_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> remaining_q != '0)
		else $error("data phase with zero remaining length");

	// Extended length and key phases always have header bytes outstanding.
	a_hdr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_EXT || phase_q == PH_MASK) |-> hdr_cnt_q != '0)
		else $error("header phase with no bytes due");

	// The last result of a frame returns the parser to the first header byte.
	a_end_hdr0: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.valid && res.frame_end |=> phase_q == PH_HDR0)
		else $error("frame end did not restart header parsing");

	// Only the empty-frame marker lacks a byte, and it always ends a frame.
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.has_byte |-> res.frame_end && res.payload_byte == 8'd0)
		else $error("malformed empty-frame marker");

endmodule
